### hw/rtl/lzrle_pkg.sv
// ----------------------------------------------------------------------------
// LZ77/RLE block decompressor package
// Shared types and constants: the block parser phases, the result status
// codes and the header layout.
// ----------------------------------------------------------------------------
package lzrle_pkg;

  // Default history depth in bytes.
  localparam int WINDOW_DEPTH_DEF = 256;

  // Header byte layout.
  localparam int LIT_FIELD_W  = 3;
  localparam int COPY_BIT     = 3;
  localparam int RUN_FIELD_LO = 4;
  localparam int RUN_FIELD_W  = 4;

  // A copy moves two bytes more than its run count says.
  localparam logic [8:0] COPY_RUN_BIAS = 9'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DIST = 2'd1;
  localparam logic [1:0] ST_REFUSED  = 2'd2;

  // Block parser phase.
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LITCOUNT,
    PH_RUNCOUNT,
    PH_LITERALS,
    PH_DISTANCE,
    PH_RUN
  } phase_t;

endpackage

### hw/rtl/lzrle_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, registered read data. A read of the
// address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module lzrle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/lz77_rle_block_decompressor_core.sv
// ----------------------------------------------------------------------------
// LZ77/RLE block decompressor core
// Parses a byte-oriented block stream (header, counts, literals, then a
// back-reference copy or a zero run) and produces decompressed bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one word per compressed byte (in_tuser = 0) or
//   per pull tick (in_tuser = 1). Literal bytes come out as they arrive;
//   each pull tick during a run or copy returns one run byte. Header, count
//   and distance bytes, and pull ticks with no run pending, give no output.
//   The output stream carries the byte, its status and tlast, which marks
//   the final byte of the block that reaches output_size.
//   cfg_data writes output_size; write it only while the block is idle.
//   A result word is registered in stage 2 and then in the output register
//   before its output handshake. Throughput: one input word per cycle while
//   the receiver does not stall, set by the single history read port, with
//   the byte written in the previous cycle forwarded around the RAM.
//   Reset clears the parser and the byte counter; the history RAM is not
//   cleared, since a valid copy only reads bytes already written.
//   When the receiver stalls, one result waits in the output register and
//   one more in the stage behind it; after that in_tready drops.
// ----------------------------------------------------------------------------
module lz77_rle_block_decompressor_core
  import lzrle_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: output_size.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] mode
  // Output stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // last
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam logic [AW-1:0] POS_LAST = AW'(WINDOW_DEPTH - 1);
  localparam logic [AW-1:0] POS_SPAN = AW'(WINDOW_DEPTH);

  // Phase after the counts are known.
  function automatic phase_t count_phase(input logic [7:0] lits, input logic copy,
                                         input logic [8:0] run);
    phase_t ph;
    if (lits != 8'd0) begin
      ph = PH_LITERALS;
    end else if (copy) begin
      ph = PH_DISTANCE;
    end else if (run != 9'd0) begin
      ph = PH_RUN;
    end else begin
      ph = PH_HEADER;
    end
    return ph;
  endfunction

  // Parser state.
  phase_t      phase_r, phase_nxt;
  logic        copy_r, copy_nxt;
  logic [3:0]  runf_r, runf_nxt;
  logic [7:0]  lits_r, lits_nxt;
  logic [8:0]  run_r, run_nxt;
  logic [7:0]  dist_r, dist_nxt;
  logic [31:0] bw_r, bw_nxt;
  logic [AW-1:0] wr_pos_r, wr_pos_nxt;
  logic [31:0] output_size_r;

  // Stage 2: waits for the registered history read.
  logic          s2_valid_r;
  logic [7:0]    s2_byte_r;
  logic [1:0]    s2_status_r;
  logic          s2_last_r;
  logic          s2_from_ram_r;
  logic          s2_fwd_r;
  logic          s2_wr_r;
  logic [AW-1:0] s2_addr_r;
  logic [7:0]    last_byte_r;

  // Output register.
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [1:0] out_status_r;
  logic       out_last_r;

  // Accept-side signals.
  logic          acc;
  logic          s2_adv;
  logic          done;
  logic          emit;
  logic [31:0]   bw_inc;
  logic [AW-1:0] rd_addr;
  logic          res_valid;
  logic [7:0]    res_byte;
  logic [1:0]    res_status;
  logic          res_last;
  logic          res_from_ram;
  logic          res_wr;
  logic          res_fwd;
  logic          bad_dist;
  logic          run_ends;
  logic          lit_ends;
  logic [7:0]    s2_value;
  logic [7:0]    ram_rdata;
  logic          ram_we;

  // Handshakes.
  assign cfg_ready = 1'b1;
  assign s2_adv    = !out_valid_r || out_tready;
  assign in_tready = !s2_valid_r || s2_adv;
  assign acc       = in_tvalid && in_tready;

  // Shared helpers for the accept decision.
  assign done     = (phase_r == PH_HEADER) && (bw_r >= output_size_r);
  assign bw_inc   = (bw_r == 32'hFFFF_FFFF) ? bw_r : bw_r + 32'd1;
  assign rd_addr  = (wr_pos_r >= AW'(dist_r)) ? wr_pos_r - AW'(dist_r)
                                              : wr_pos_r + POS_SPAN - AW'(dist_r);
  assign bad_dist = (dist_r == 8'd0) || ({24'd0, dist_r} > bw_r);
  assign run_ends = (run_r == 9'd1);
  assign lit_ends = (lits_r == 8'd1) && !copy_r && (run_r == 9'd0);

  // Counters and the result of the accepted word.
  always_comb begin
    copy_nxt     = copy_r;
    runf_nxt     = runf_r;
    lits_nxt     = lits_r;
    run_nxt      = run_r;
    dist_nxt     = dist_r;
    emit         = 1'b0;
    res_valid    = 1'b0;
    res_byte     = 8'd0;
    res_status   = ST_OK;
    res_last     = 1'b0;
    res_from_ram = 1'b0;
    if (acc) begin
      if (in_tuser) begin
        // Pull tick: one run or copy byte.
        if (phase_r == PH_RUN) begin
          run_nxt      = run_r - 9'd1;
          emit         = 1'b1;
          res_valid    = 1'b1;
          res_status   = (copy_r && bad_dist) ? ST_BAD_DIST : ST_OK;
          res_from_ram = copy_r && !bad_dist;
          res_last     = run_ends && (bw_inc >= output_size_r);
        end
      end else if (done || phase_r == PH_RUN) begin
        // Byte mid-run or after the end of the job.
        res_valid  = 1'b1;
        res_status = ST_REFUSED;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            copy_nxt = in_tdata[COPY_BIT];
            runf_nxt = in_tdata[RUN_FIELD_LO +: RUN_FIELD_W];
            lits_nxt = {5'd0, in_tdata[LIT_FIELD_W-1:0]} - 8'd1;
            if (in_tdata[LIT_FIELD_W-1:0] != 3'd0 && runf_nxt != 4'd0) begin
              run_nxt = {5'd0, runf_nxt} + (copy_nxt ? COPY_RUN_BIAS : 9'd0);
            end
          end
          PH_LITCOUNT: begin
            lits_nxt = in_tdata - 8'd1;
            if (runf_r != 4'd0) begin
              run_nxt = {5'd0, runf_r} + (copy_r ? COPY_RUN_BIAS : 9'd0);
            end
          end
          PH_RUNCOUNT: begin
            run_nxt = {1'b0, in_tdata} + (copy_r ? COPY_RUN_BIAS : 9'd0);
          end
          PH_LITERALS: begin
            lits_nxt  = lits_r - 8'd1;
            emit      = 1'b1;
            res_valid = 1'b1;
            res_byte  = in_tdata;
            res_last  = lit_ends && (bw_inc >= output_size_r);
          end
          PH_DISTANCE: begin
            dist_nxt = in_tdata;
          end
          default: begin
          end
        endcase
      end
    end
    bw_nxt     = emit ? bw_inc : bw_r;
    wr_pos_nxt = emit ? ((wr_pos_r == POS_LAST) ? '0 : wr_pos_r + AW'(1)) : wr_pos_r;
    res_wr     = emit;
    res_fwd    = s2_valid_r && s2_wr_r && (rd_addr == s2_addr_r);
  end

  // Parser next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      if (in_tuser) begin
        if (phase_r == PH_RUN && run_ends) begin
          phase_nxt = PH_HEADER;
        end
      end else if (!(done || phase_r == PH_RUN)) begin
        unique case (phase_r)
          PH_HEADER: begin
            if (in_tdata[LIT_FIELD_W-1:0] == 3'd0) begin
              phase_nxt = PH_LITCOUNT;
            end else if (runf_nxt == 4'd0) begin
              phase_nxt = PH_RUNCOUNT;
            end else begin
              phase_nxt = count_phase(lits_nxt, copy_nxt, run_nxt);
            end
          end
          PH_LITCOUNT: begin
            if (runf_r == 4'd0) begin
              phase_nxt = PH_RUNCOUNT;
            end else begin
              phase_nxt = count_phase(lits_nxt, copy_r, run_nxt);
            end
          end
          PH_RUNCOUNT: begin
            phase_nxt = count_phase(lits_r, copy_r, run_nxt);
          end
          PH_LITERALS: begin
            if (lits_nxt == 8'd0) begin
              phase_nxt = count_phase(8'd0, copy_r, run_r);
            end
          end
          PH_DISTANCE: begin
            phase_nxt = PH_RUN;
          end
          default: begin
            phase_nxt = PH_HEADER;
          end
        endcase
      end
    end
  end

  // Parser and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      copy_r        <= 1'b0;
      runf_r        <= 4'd0;
      lits_r        <= 8'd0;
      run_r         <= 9'd0;
      dist_r        <= 8'd0;
      bw_r          <= 32'd0;
      wr_pos_r      <= '0;
      output_size_r <= 32'd0;
      s2_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      copy_r   <= copy_nxt;
      runf_r   <= runf_nxt;
      lits_r   <= lits_nxt;
      run_r    <= run_nxt;
      dist_r   <= dist_nxt;
      bw_r     <= bw_nxt;
      wr_pos_r <= wr_pos_nxt;
      if (cfg_valid && cfg_ready) begin
        output_size_r <= cfg_data;
      end
      if (in_tready) begin
        s2_valid_r <= acc && res_valid;
      end
      if (s2_adv) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // Stage 2 payload.
  always_ff @(posedge clk) begin
    if (acc) begin
      s2_byte_r     <= res_byte;
      s2_status_r   <= res_status;
      s2_last_r     <= res_last;
      s2_from_ram_r <= res_from_ram;
      s2_fwd_r      <= res_fwd;
      s2_wr_r       <= res_wr;
      s2_addr_r     <= wr_pos_r;
    end
  end

  // The byte a copy reads may be the one written in the previous cycle.
  assign s2_value = s2_from_ram_r ? (s2_fwd_r ? last_byte_r : ram_rdata) : s2_byte_r;
  assign ram_we   = s2_valid_r && s2_adv && s2_wr_r;

  // History write-back and the forwarding copy of the last byte written.
  always_ff @(posedge clk) begin
    if (ram_we) begin
      last_byte_r <= s2_value;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (s2_adv && s2_valid_r) begin
      out_byte_r   <= s2_value;
      out_status_r <= s2_status_r;
      out_last_r   <= s2_last_r;
    end
  end

  // History window.
  lzrle_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s2_addr_r),
    .wdata (s2_value),
    .re    (acc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // A run phase always has bytes left to give.
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_RUN |-> run_r != 9'd0)
    else $error("run phase with no bytes left");

  // A stalled stage-2 word is kept until the output register frees up.
  assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !s2_adv |=> s2_valid_r && $stable(s2_status_r) && $stable(s2_addr_r))
    else $error("stage 2 word lost under stall");

  // A refused word is a zero byte and never ends the job.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_REFUSED |-> !out_last_r && out_byte_r == 8'd0)
    else $error("refused word carries data or last");

  // The history write position stays inside the window.
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_pos_r <= POS_LAST)
    else $error("history position outside window");

endmodule
